// ===== design/pbrl_pkg.sv =====
// Package for the paged bitmap rank lookup: payload structs, action codes,
// size defaults and the byte popcount helper. No dependencies.
`default_nettype none
package pbrl_pkg;

  localparam int unsigned MAP_DEPTH_DEF     = 4352;
  localparam int unsigned COMPACT_PAGES_DEF = 255;
  localparam int unsigned WORDS_PER_PAGE    = 4;
  localparam int unsigned PAGE_NUM_W        = 13;
  localparam int unsigned INDEX_W           = 17;

  localparam logic [7:0] ABSENT_PAGE = 8'hFF;

  typedef enum logic [2:0] {
    ACT_LOOKUP    = 3'd0,
    ACT_WR_MAP    = 3'd1,
    ACT_WR_WORD   = 3'd2,
    ACT_WR_RANKS  = 3'd3,
    ACT_WR_START  = 3'd4
  } action_e;

  typedef struct packed {
    logic [2:0]  action;
    logic [20:0] codepoint;
    logic [12:0] table_addr;
    logic [63:0] table_data;
  } in_t;

  typedef struct packed {
    logic        found;
    logic [16:0] dense_index;
  } out_t;

  function automatic logic [3:0] popcount8(input logic [7:0] b);
    logic [3:0] n;
    n = 4'd0;
    for (int i = 0; i < 8; i++) begin
      n = n + {3'd0, b[i]};
    end
    return n;
  endfunction

endpackage
`default_nettype wire

// ===== design/paged_bitmap_rank_lookup.sv =====
// Top level of the paged bitmap rank lookup: four-stage pipeline with the
// page map, presence word, rank and page start memories. Depends on pbrl_pkg.
//
// Maps a 21-bit code point to a dense entry index. The top 13 bits pick an
// entry of the page map (a compact page number, or 0xFF for absent); the
// compact page selects one of four 64-bit presence words by code point bits
// [7:6], a rank byte and a 16-bit page start. On a hit the index is start +
// rank + the number of presence bits set below the code point's bit. Write
// transactions (actions 1 to 4) load one table entry each and return a result
// with found = 0. One transaction is accepted every cycle unless the output
// stalls; each result appears in the fourth of four register stages: page
// map read, table reads, popcount of the masked word by bytes, final add into
// the output register. Writes take effect in order with lookups, so a lookup
// sees every earlier write. After reset the page map is swept to absent, one
// entry a cycle over all MAP_DEPTH entries, during which in_ready_o stays low.
`default_nettype none
module paged_bitmap_rank_lookup
  import pbrl_pkg::*;
#(
  parameter int unsigned MAP_DEPTH     = MAP_DEPTH_DEF,
  parameter int unsigned COMPACT_PAGES = COMPACT_PAGES_DEF
) (
  input  wire logic clk_i,
  input  wire logic rst_ni,
  input  wire logic in_valid_i,
  output logic      in_ready_o,
  input  wire in_t  in_data_i,
  output logic      out_valid_o,
  input  wire logic out_ready_i,
  output out_t      out_data_o
);

  localparam int unsigned PM_AW    = (MAP_DEPTH > 1) ? $clog2(MAP_DEPTH) : 1;
  localparam int unsigned CP_AW    = (COMPACT_PAGES > 1) ? $clog2(COMPACT_PAGES) : 1;
  localparam int unsigned PW_AW    = CP_AW + 2;
  localparam int unsigned PW_DEPTH = COMPACT_PAGES * WORDS_PER_PAGE;

  localparam logic [13:0]      PAGE_LIMIT = 14'(MAP_DEPTH);
  localparam logic [13:0]      PW_LIMIT   = 14'(PW_DEPTH);
  localparam logic [13:0]      CP_ADDR_LIM = 14'(COMPACT_PAGES);
  localparam logic [7:0]       CP_LIMIT   = 8'(COMPACT_PAGES);
  localparam logic [PM_AW-1:0] CLR_LAST   = PM_AW'(MAP_DEPTH - 1);

  // Memories
  logic [7:0]  pm_mem    [MAP_DEPTH];
  logic [63:0] pw_mem    [PW_DEPTH];
  logic [31:0] rank_mem  [COMPACT_PAGES];
  logic [15:0] start_mem [COMPACT_PAGES];

  // Handshake and stage control
  logic in_acc, adv2;
  logic rdy1, rdy2, rdy3, rdy_o;
  logic v1_q, v2_q, v3_q, vo_q;

  // Clearing sweep
  logic             clr_busy_q;
  logic [PM_AW-1:0] clr_cnt_q;

  // Stage 1: page map entry read
  logic [7:0]  pm_rd_q;
  logic        s1_page_ok_q;
  logic [2:0]  s1_action_q;
  logic [7:0]  s1_low_q;
  logic [12:0] s1_addr_q;
  logic [63:0] s1_data_q;

  // Stage 2: table reads
  logic [63:0] pw_rd_q;
  logic [31:0] rank_rd_q;
  logic [15:0] start_rd_q;
  logic        s2_cp_ok_q;
  logic [7:0]  s2_low_q;

  // Stage 3: byte counts
  logic       s3_hit_q;
  logic [3:0] s3_cnt_q [8];
  logic [7:0] s3_rank_q;
  logic [15:0] s3_start_q;

  out_t out_q;

  // Ready chain: each stage frees when its successor moves.
  assign rdy_o      = !vo_q || out_ready_i;
  assign rdy3       = !v3_q || rdy_o;
  assign rdy2       = !v2_q || rdy3;
  assign rdy1       = !v1_q || rdy2;
  assign in_ready_o = rdy1 && !clr_busy_q;
  assign in_acc     = in_valid_i && in_ready_o;
  assign adv2       = v1_q && rdy2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q <= 1'b0;
      v2_q <= 1'b0;
      v3_q <= 1'b0;
      vo_q <= 1'b0;
    end else begin
      if (rdy1) v1_q <= in_acc;
      if (rdy2) v2_q <= v1_q;
      if (rdy3) v3_q <= v2_q;
      if (rdy_o) vo_q <= v3_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_busy_q <= 1'b1;
      clr_cnt_q  <= '0;
    end else if (clr_busy_q) begin
      if (clr_cnt_q == CLR_LAST) begin
        clr_busy_q <= 1'b0;
      end else begin
        clr_cnt_q <= clr_cnt_q + 1'b1;
      end
    end
  end

  // ---------------- Stage 0 -> 1: page map access ----------------
  logic [12:0]      in_page;
  logic             in_page_ok;
  logic [PM_AW-1:0] pm_raddr;
  logic             pm_we;
  logic [PM_AW-1:0] pm_waddr;
  logic [7:0]       pm_wdata;

  always_comb begin
    in_page    = in_data_i.codepoint[20:8];
    in_page_ok = (in_data_i.action == ACT_LOOKUP) && ({1'b0, in_page} < PAGE_LIMIT);
    pm_raddr   = in_page_ok ? in_page[PM_AW-1:0] : '0;
    if (clr_busy_q) begin
      pm_we    = 1'b1;
      pm_waddr = clr_cnt_q;
      pm_wdata = ABSENT_PAGE;
    end else begin
      pm_we    = in_acc && (in_data_i.action == ACT_WR_MAP)
                 && ({1'b0, in_data_i.table_addr} < PAGE_LIMIT);
      pm_waddr = in_data_i.table_addr[PM_AW-1:0];
      pm_wdata = in_data_i.table_data[7:0];
    end
  end

  always_ff @(posedge clk_i) begin
    if (pm_we) pm_mem[pm_waddr] <= pm_wdata;
    if (in_acc) pm_rd_q <= pm_mem[pm_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (in_acc) begin
      s1_page_ok_q <= in_page_ok;
      s1_action_q  <= in_data_i.action;
      s1_low_q     <= in_data_i.codepoint[7:0];
      s1_addr_q    <= in_data_i.table_addr;
      s1_data_q    <= in_data_i.table_data;
    end
  end

  // ---------------- Stage 1 -> 2: compact page tables ----------------
  logic             s1_cp_ok;
  logic [CP_AW-1:0] cp_idx;
  logic [PW_AW-1:0] pw_raddr;
  logic             pw_we, rank_we, start_we;

  always_comb begin
    s1_cp_ok = s1_page_ok_q && (pm_rd_q != ABSENT_PAGE) && (pm_rd_q < CP_LIMIT);
    cp_idx   = s1_cp_ok ? pm_rd_q[CP_AW-1:0] : '0;
    pw_raddr = {cp_idx, s1_low_q[7:6]};
    pw_we    = adv2 && (s1_action_q == ACT_WR_WORD)
               && ({1'b0, s1_addr_q} < PW_LIMIT);
    rank_we  = adv2 && (s1_action_q == ACT_WR_RANKS)
               && ({1'b0, s1_addr_q} < CP_ADDR_LIM);
    start_we = adv2 && (s1_action_q == ACT_WR_START)
               && ({1'b0, s1_addr_q} < CP_ADDR_LIM);
  end

  always_ff @(posedge clk_i) begin
    if (pw_we) pw_mem[s1_addr_q[PW_AW-1:0]] <= s1_data_q;
    if (adv2) pw_rd_q <= pw_mem[pw_raddr];
  end

  always_ff @(posedge clk_i) begin
    if (rank_we) rank_mem[s1_addr_q[CP_AW-1:0]] <= s1_data_q[31:0];
    if (adv2) rank_rd_q <= rank_mem[cp_idx];
  end

  always_ff @(posedge clk_i) begin
    if (start_we) start_mem[s1_addr_q[CP_AW-1:0]] <= s1_data_q[15:0];
    if (adv2) start_rd_q <= start_mem[cp_idx];
  end

  always_ff @(posedge clk_i) begin
    if (adv2) begin
      s2_cp_ok_q <= s1_cp_ok;
      s2_low_q   <= s1_low_q;
    end
  end

  // ---------------- Stage 2 -> 3: presence test, byte counts ----------------
  logic [5:0]  s2_bit;
  logic [63:0] s2_masked;
  logic        s2_hit;
  logic [7:0]  s2_rank;

  always_comb begin
    s2_bit    = s2_low_q[5:0];
    s2_masked = pw_rd_q & ((64'd1 << s2_bit) - 64'd1);
    s2_hit    = s2_cp_ok_q && pw_rd_q[s2_bit];
    s2_rank   = rank_rd_q[{s2_low_q[7:6], 3'b000} +: 8];
  end

  always_ff @(posedge clk_i) begin
    if (rdy3 && v2_q) begin
      s3_hit_q   <= s2_hit;
      s3_rank_q  <= s2_rank;
      s3_start_q <= start_rd_q;
      for (int i = 0; i < 8; i++) begin
        s3_cnt_q[i] <= popcount8(s2_masked[i*8 +: 8]);
      end
    end
  end

  // ---------------- Stage 3 -> out: final sum ----------------
  logic [6:0]         s3_pop;
  logic [INDEX_W-1:0] s3_index;

  always_comb begin
    s3_pop = 7'd0;
    for (int i = 0; i < 8; i++) begin
      s3_pop = s3_pop + {3'd0, s3_cnt_q[i]};
    end
    s3_index = {1'b0, s3_start_q} + {9'd0, s3_rank_q} + {10'd0, s3_pop};
  end

  always_ff @(posedge clk_i) begin
    if (rdy_o && v3_q) begin
      out_q.found       <= s3_hit_q;
      out_q.dense_index <= s3_hit_q ? s3_index : '0;
    end
  end

  assign out_valid_o = vo_q;
  assign out_data_o  = out_q;

`ifndef SYNTHESIS
  a_no_accept_in_clear : assert property (@(posedge clk_i) disable iff (!rst_ni)
    clr_busy_q |-> !in_ready_o)
    else $error("transaction accepted during page map clear");

  a_accept_fills_s1 : assert property (@(posedge clk_i) disable iff (!rst_ni)
    in_acc |=> v1_q)
    else $error("accepted transaction lost at stage 1");

  a_s3_held_on_stall : assert property (@(posedge clk_i) disable iff (!rst_ni)
    v3_q && !rdy3 |=> v3_q && $stable(s3_hit_q) && $stable(s3_start_q))
    else $error("stage 3 changed while stalled");

  a_miss_zero_index : assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_data_o.found |-> out_data_o.dense_index == '0)
    else $error("non-zero index on a miss");
`endif

endmodule
`default_nettype wire

// ===== tb/testbench.sv =====
// Self-checking testbench for paged_bitmap_rank_lookup: directed and random
// table loads and code point lookups, checked against a behavioural predictor.
// Depends on pbrl_pkg and the paged_bitmap_rank_lookup top level.
`default_nettype none
module testbench;
  import pbrl_pkg::*;

  localparam int unsigned ITEM_TOTAL     = 1800;
  // The page map sweep after reset holds in_ready_o low while it clears all
  // MAP_DEPTH entries, so the quiet-cycle limit sits well above that sweep.
  localparam int unsigned WATCHDOG_LIMIT = 20000;
  localparam int unsigned TAIL_CYCLES    = 8;
  localparam int unsigned ACT_CODE_MAX   = 7;
  localparam int unsigned WORD_COUNT     = COMPACT_PAGES_DEF * WORDS_PER_PAGE;

  // Scoreboard: keeps its own copy of the four tables, works out the result
  // of every accepted request and checks results in order.
  class rank_lookup_scoreboard;
    logic [7:0]  page_map [MAP_DEPTH_DEF];
    logic [63:0] presence [WORD_COUNT];
    logic [31:0] ranks    [COMPACT_PAGES_DEF];
    logic [15:0] starts   [COMPACT_PAGES_DEF];
    out_t        expected_results [$];
    int unsigned errors;

    function new();
      foreach (page_map[i]) page_map[i] = ABSENT_PAGE;
      foreach (presence[i]) presence[i] = '0;
      foreach (ranks[i]) ranks[i] = '0;
      foreach (starts[i]) starts[i] = '0;
      errors = 0;
    endfunction

    function int unsigned outstanding();
      return expected_results.size();
    endfunction

    function void note_request(in_t req);
      out_t        res;
      logic [12:0] page;
      logic [7:0]  cpage;
      logic [1:0]  wsel;
      logic [5:0]  bitpos;
      logic [63:0] word;
      logic [7:0]  rank;
      int unsigned ones;
      res = '0;
      case (req.action)
        ACT_LOOKUP: begin
          page = req.codepoint[20:8];
          if (page < MAP_DEPTH_DEF) begin
            cpage = page_map[page];
            if (cpage != ABSENT_PAGE && cpage < COMPACT_PAGES_DEF) begin
              wsel   = req.codepoint[7:6];
              bitpos = req.codepoint[5:0];
              word   = presence[cpage * WORDS_PER_PAGE + wsel];
              if (word[bitpos]) begin
                rank = ranks[cpage][wsel * 8 +: 8];
                ones = 0;
                for (int b = 0; b < bitpos; b++) ones += word[b];
                res.found       = 1'b1;
                res.dense_index = 17'(starts[cpage] + rank + ones);
              end
            end
          end
        end
        ACT_WR_MAP: begin
          if (req.table_addr < MAP_DEPTH_DEF) page_map[req.table_addr] = req.table_data[7:0];
        end
        ACT_WR_WORD: begin
          if (req.table_addr < WORD_COUNT) presence[req.table_addr] = req.table_data;
        end
        ACT_WR_RANKS: begin
          if (req.table_addr < COMPACT_PAGES_DEF) ranks[req.table_addr] = req.table_data[31:0];
        end
        ACT_WR_START: begin
          if (req.table_addr < COMPACT_PAGES_DEF) starts[req.table_addr] = req.table_data[15:0];
        end
        default: begin
        end
      endcase
      expected_results.push_back(res);
    endfunction

    function void check_result(out_t got);
      out_t want;
      if (expected_results.size() == 0) begin
        $display("%0t: result with none expected, actual found=%0d dense_index=%0d",
                 $time, got.found, got.dense_index);
        errors++;
        return;
      end
      want = expected_results.pop_front();
      if (got.found !== want.found) begin
        $display("%0t: found mismatch, expected %0d, actual %0d", $time, want.found, got.found);
        errors++;
      end
      if (got.dense_index !== want.dense_index) begin
        $display("%0t: dense_index mismatch, expected %0d, actual %0d",
                 $time, want.dense_index, got.dense_index);
        errors++;
      end
    endfunction
  endclass

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  in_t  in_data_i   = '0;
  logic out_ready_i = 1'b0;
  logic in_ready_o;
  logic out_valid_o;
  out_t out_data_o;

  paged_bitmap_rank_lookup DUT (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_data_i   (in_data_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_data_o  (out_data_o)
  );

  rank_lookup_scoreboard sb;

  // Stimulus-side bookkeeping: which compact pages are fully loaded, and which
  // pages have been pointed at one. Lookups can then never read a presence
  // word, rank or start that was never written.
  bit          word_loaded  [WORD_COUNT];
  bit          rank_loaded  [COMPACT_PAGES_DEF];
  bit          start_loaded [COMPACT_PAGES_DEF];
  int unsigned mapped_pages [$];
  int unsigned items_sent   = 0;
  bit          calm         = 1'b0;   // no idling on either side once set
  bit          drained_mid  = 1'b0;
  int unsigned quiet_cycles = 0;

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  function automatic bit page_loaded(int unsigned c);
    return rank_loaded[c] && start_loaded[c] && word_loaded[c * WORDS_PER_PAGE] &&
           word_loaded[c * WORDS_PER_PAGE + 1] && word_loaded[c * WORDS_PER_PAGE + 2] &&
           word_loaded[c * WORDS_PER_PAGE + 3];
  endfunction

  function automatic in_t lookup_req(logic [20:0] cp);
    in_t r;
    r.action     = ACT_LOOKUP;
    r.codepoint  = cp;
    r.table_addr = 13'($urandom);
    r.table_data = {$urandom, $urandom};
    return r;
  endfunction

  function automatic in_t write_req(logic [2:0] act, int unsigned addr, logic [63:0] data);
    in_t r;
    r.action     = act;
    r.codepoint  = 21'($urandom);
    r.table_addr = 13'(addr);
    r.table_data = data;
    return r;
  endfunction

  // Presence words of mixed density so that popcounts span the full range
  function automatic logic [63:0] rand_word();
    case ($urandom_range(0, 5))
      0: return '1;
      1: return '0;
      2: return {$urandom, $urandom} & {$urandom, $urandom} & {$urandom, $urandom};
      3: return {$urandom, $urandom} | {$urandom, $urandom};
      default: return {$urandom, $urandom};
    endcase
  endfunction

  // A code point on a page that has been mapped at some point, or anywhere
  function automatic logic [20:0] mapped_cp();
    if (mapped_pages.size() == 0) return 21'($urandom);
    return {13'(mapped_pages[$urandom_range(0, mapped_pages.size() - 1)]), 8'($urandom)};
  endfunction

  // Drive one transaction and wait until it is accepted. Valid is left high;
  // an idle burst in the next call, or a drain, lowers it.
  task automatic send(input in_t req);
    if (!calm && $urandom_range(0, 7) == 0) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(1, 16)) @(posedge clk_i);
    end
    // a map entry may only point at a compact page whose tables are all loaded
    if (req.action == ACT_WR_MAP && req.table_addr < MAP_DEPTH_DEF &&
        req.table_data[7:0] != ABSENT_PAGE && !page_loaded(req.table_data[7:0]))
      req.table_data[7:0] = ABSENT_PAGE;
    case (req.action)
      ACT_WR_MAP: begin
        if (req.table_addr < MAP_DEPTH_DEF && req.table_data[7:0] != ABSENT_PAGE)
          mapped_pages.push_back(req.table_addr);
      end
      ACT_WR_WORD:  if (req.table_addr < WORD_COUNT) word_loaded[req.table_addr] = 1'b1;
      ACT_WR_RANKS: if (req.table_addr < COMPACT_PAGES_DEF) rank_loaded[req.table_addr] = 1'b1;
      ACT_WR_START: if (req.table_addr < COMPACT_PAGES_DEF) start_loaded[req.table_addr] = 1'b1;
      default: begin
      end
    endcase
    in_valid_i <= 1'b1;
    in_data_i  <= req;
    @(posedge clk_i);
    while (!in_ready_o) @(posedge clk_i);
    items_sent++;
  endtask

  // Hold off the sender until every outstanding result has come back
  task automatic drain();
    in_valid_i <= 1'b0;
    @(posedge clk_i);
    while (sb.outstanding() != 0) @(posedge clk_i);
  endtask

  // Monitor and watchdog. Handshakes are sampled in the active region of the
  // edge, so they see the values from before that edge.
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (in_valid_i && in_ready_o) sb.note_request(in_data_i);
      if (out_valid_o && out_ready_i) sb.check_result(out_data_o);
      if ((in_valid_i && in_ready_o) || (out_valid_o && out_ready_i)) begin
        quiet_cycles <= 0;
      end else if (quiet_cycles == WATCHDOG_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end else begin
        quiet_cycles <= quiet_cycles + 1;
      end
    end
  end

  // Receiver: random stall bursts between stretches of readiness
  initial begin
    @(posedge clk_i);
    forever begin
      if (!calm && $urandom_range(0, 2) == 0) begin
        out_ready_i <= 1'b0;
        repeat ($urandom_range(1, 16)) @(posedge clk_i);
      end
      out_ready_i <= 1'b1;
      repeat ($urandom_range(1, 40)) @(posedge clk_i);
    end
  end

  initial begin
    int unsigned c;
    int unsigned page;
    int unsigned n;
    int unsigned addr;
    logic [2:0]  act;
    sb = new();
    repeat (4) @(posedge clk_i);
    rst_ni <= 1'b1;

    // Directed part. Nothing mapped yet: absent page, then a page past the map.
    send(lookup_req(21'h000000));
    send(lookup_req(21'h1FFFFF));
    // compact page 0 loaded with edge values: word 3 all ones, every rank byte
    // 0xFF and start 0xFFFF give the largest index on its top bit
    send(write_req(ACT_WR_WORD, 0, 64'h8000_0000_0000_0001));
    send(write_req(ACT_WR_WORD, 1, 64'h0));
    send(write_req(ACT_WR_WORD, 2, 64'hAAAA_AAAA_AAAA_AAAA));
    send(write_req(ACT_WR_WORD, 3, '1));
    send(write_req(ACT_WR_RANKS, 0, '1));
    send(write_req(ACT_WR_START, 0, '1));
    send(write_req(ACT_WR_MAP, MAP_DEPTH_DEF - 1, 64'hFFFF_FFFF_FFFF_FF00));
    send(lookup_req({13'(MAP_DEPTH_DEF - 1), 8'hFF}));   // largest index
    send(lookup_req({13'(MAP_DEPTH_DEF - 1), 8'h00}));   // lowest bit of word 0
    send(lookup_req({13'(MAP_DEPTH_DEF - 1), 8'h3F}));   // top bit of word 0
    send(lookup_req({13'(MAP_DEPTH_DEF - 1), 8'h40}));   // empty word
    send(lookup_req({13'(MAP_DEPTH_DEF - 1), 8'h81}));   // alternating word
    // writes just past the end of each table, and at the top address
    send(write_req(ACT_WR_MAP, MAP_DEPTH_DEF, 64'h0));
    send(write_req(ACT_WR_WORD, WORD_COUNT, 64'h0));
    send(write_req(ACT_WR_RANKS, COMPACT_PAGES_DEF, 64'h0));
    send(write_req(ACT_WR_START, COMPACT_PAGES_DEF, 64'h0));
    send(write_req(ACT_WR_WORD, 8191, 64'h0));
    send(lookup_req(21'h0000C3));
    send(lookup_req({13'(MAP_DEPTH_DEF), 8'h00}));        // first page past the map
    // spare action codes change nothing
    for (int a = ACT_WR_START + 1; a <= ACT_CODE_MAX; a++)
      send(write_req(3'(a), 0, '1));
    drain();

    // Random part: mostly well-formed load-then-lookup sequences
    while (items_sent < ITEM_TOTAL) begin
      if (items_sent > ITEM_TOTAL * 9 / 10) calm = 1'b1;
      if (!drained_mid && items_sent >= ITEM_TOTAL / 2) begin
        drain();
        drained_mid = 1'b1;
      end
      case ($urandom_range(0, 9))
        0, 1, 2: begin
          // load a compact page, point a few pages at it, look into them
          c = $urandom_range(0, COMPACT_PAGES_DEF - 1);
          for (int w = 0; w < WORDS_PER_PAGE; w++)
            send(write_req(ACT_WR_WORD, c * WORDS_PER_PAGE + w, rand_word()));
          send(write_req(ACT_WR_RANKS, c, {$urandom, $urandom}));
          send(write_req(ACT_WR_START, c, {$urandom, $urandom}));
          n = $urandom_range(1, 3);
          repeat (n) begin
            page = $urandom_range(0, MAP_DEPTH_DEF - 1);
            send(write_req(ACT_WR_MAP, page, {24'($urandom), $urandom, 8'(c)}));
            repeat ($urandom_range(2, 5)) send(lookup_req({13'(page), 8'($urandom)}));
          end
        end
        3, 4, 5: begin
          repeat ($urandom_range(4, 12)) send(lookup_req(mapped_cp()));
        end
        6: begin
          // unmap a page or move it to another compact page
          addr = mapped_cp() >> 8;
          if ($urandom_range(0, 1) == 0)
            send(write_req(ACT_WR_MAP, addr, {24'($urandom), $urandom, ABSENT_PAGE}));
          else
            send(write_req(ACT_WR_MAP, addr,
                           {$urandom, $urandom} & 64'hFFFF_FFFF_FFFF_FF00 |
                           64'($urandom_range(0, COMPACT_PAGES_DEF - 1))));
          repeat ($urandom_range(1, 4)) send(lookup_req(mapped_cp()));
        end
        7: begin
          // noise: any action, any fields
          repeat ($urandom_range(1, 4))
            send(write_req(3'($urandom_range(0, ACT_CODE_MAX)), $urandom_range(0, 8191),
                           {$urandom, $urandom}));
        end
        8: begin
          // writes beyond the end of the selected table
          act = 3'($urandom_range(ACT_WR_MAP, ACT_WR_START));
          case (act)
            ACT_WR_MAP:  addr = $urandom_range(MAP_DEPTH_DEF, 8191);
            ACT_WR_WORD: addr = $urandom_range(WORD_COUNT, 8191);
            default:     addr = $urandom_range(COMPACT_PAGES_DEF, 8191);
          endcase
          send(write_req(act, addr, {$urandom, $urandom}));
          send(lookup_req(mapped_cp()));
        end
        default: begin
          // overwrite one table entry of a compact page, then look again
          c = $urandom_range(0, COMPACT_PAGES_DEF - 1);
          case ($urandom_range(0, 2))
            0: send(write_req(ACT_WR_WORD, c * WORDS_PER_PAGE + $urandom_range(0, 3),
                              rand_word()));
            1: send(write_req(ACT_WR_RANKS, c, {$urandom, $urandom}));
            default: send(write_req(ACT_WR_START, c, {$urandom, $urandom}));
          endcase
          repeat ($urandom_range(2, 6)) send(lookup_req(mapped_cp()));
        end
      endcase
    end

    drain();
    repeat (TAIL_CYCLES) @(posedge clk_i);
    if (sb.errors == 0)
      $display("Testbench completed without errors");
    else
      $display("Testbench completed WITH ERRORS");
    $finish;
  end

endmodule
`default_nettype wire
